// ----- design/apb_pkg.sv -----
// Shared types, constants and helpers for the alpha-over pixel blend unit.
// No dependencies; compiled first.
package apb_pkg;

   localparam int PIX_W      = 8;
   localparam int PROD_W     = 2 * PIX_W;
   localparam int NUM_W      = 3 * PIX_W;
   localparam int DIV_STAGES = PIX_W;
   localparam int LANES      = 3;

   localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [PIX_W-1:0] ALPHA_CLEAR  = 8'd0;

   typedef logic [PIX_W-1:0]  pixel_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [NUM_W-1:0]  num_type;

   typedef enum logic {
      DRAW_BLEND     = 1'b0,
      DRAW_OVERWRITE = 1'b1
   } draw_mode_type;

   typedef struct packed {
      pixel_type src_alpha;
      pixel_type src_red;
      pixel_type src_green;
      pixel_type src_blue;
      pixel_type dst_alpha;
      pixel_type dst_red;
      pixel_type dst_green;
      pixel_type dst_blue;
   } req_payload_type;

   typedef struct packed {
      pixel_type out_alpha;
      pixel_type out_red;
      pixel_type out_green;
      pixel_type out_blue;
      logic      write_pixel;
   } rsp_payload_type;

   // floor(s / 255), exact for any 16-bit s whose quotient fits in PIX_W bits (s <= 65279)
   function automatic pixel_type alpha_div255(input prod_type s);
      logic [PROD_W:0] t;
      t = (PROD_W+1)'(s) + (PROD_W+1)'(1) + (PROD_W+1)'(s[PROD_W-1:PIX_W]);
      return t[PROD_W-1:PIX_W];
   endfunction

endpackage

// ----- design/apb_chan_if.sv -----
// Valid/ready channel carrying one payload item per handshake.
// Payload type is supplied at instantiation, usually from apb_pkg.
interface apb_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/apb_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on apb_pkg; quotient is assumed to fit in PIX_W bits.
module apb_div_pipe import apb_pkg::*; (
   input  logic      clock,
   input  logic      advance,
   input  num_type   num_in,
   input  prod_type  den_in,
   output pixel_type quo_out
);

   num_type   rem_ff [DIV_STAGES];
   prod_type  den_ff [DIV_STAGES];
   pixel_type quo_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      num_type        rem_prev;
      prod_type       den_prev;
      pixel_type      quo_prev;
      num_type        shifted;
      logic [NUM_W:0] diff;
      logic           take;
      num_type        rem_in;
      pixel_type      quo_in;

      if (k == 0) begin : g_first
         assign rem_prev = num_in;
         assign den_prev = den_in;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      always_comb begin
         shifted = NUM_W'(den_prev) << (DIV_STAGES - 1 - k);
         diff    = {1'b0, rem_prev} - {1'b0, shifted};
         take    = !diff[NUM_W];
         rem_in  = take ? diff[NUM_W-1:0] : rem_prev;
         quo_in  = {quo_prev[PIX_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo_out = quo_ff[DIV_STAGES-1];

endmodule

// ----- design/alpha_over_pixel_blend_unit.sv -----
// Alpha-over pixel blend unit: straight-alpha ARGB8888 source over destination.
// Pipeline: 2 product stages, then one stage per quotient bit of the 8-stage
// divider, between request accept and response valid. Throughput: one item
// per cycle; the whole pipeline holds while a response waits on rsp_if.ready.
// Reset (synchronous, active high) empties the pipeline and selects blend mode.
// Depends on apb_pkg, apb_chan_if and apb_div_pipe.
module alpha_over_pixel_blend_unit import apb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   apb_chan_if.sink   req_if,
   apb_chan_if.source rsp_if,
   apb_chan_if.sink   csr_if
);

   draw_mode_type draw_mode_ff;
   logic          advance;

   // stage 1
   logic            v1_ff;
   logic            pass1_ff;
   rsp_payload_type pass_rsp1_ff;
   pixel_type       as1_ff;
   prod_type        w1_ff;
   prod_type        ps1_ff [LANES];
   pixel_type       cd1_ff [LANES];

   logic            pass1_in;
   rsp_payload_type pass_rsp1_in;
   prod_type        w1_in;
   prod_type        ps1_in [LANES];
   pixel_type       cs_in [LANES];
   pixel_type       cd_in [LANES];

   // stage 2
   logic            v2_ff;
   logic            pass2_ff;
   rsp_payload_type pass_rsp2_ff;
   prod_type        s2_ff;
   num_type         num2_ff [LANES];
   prod_type        s2_in;
   num_type         num2_in [LANES];

   // side line beside the divider
   logic            sv_ff   [DIV_STAGES];
   logic            spass_ff[DIV_STAGES];
   rsp_payload_type srsp_ff [DIV_STAGES];
   pixel_type       salpha_ff [DIV_STAGES];
   pixel_type       quo [LANES];

   assign advance      = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = advance;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff <= DRAW_BLEND;
      end else if (csr_if.valid) begin
         draw_mode_ff <= draw_mode_type'(csr_if.payload);
      end
   end

   always_comb begin
      cs_in[0] = req_if.payload.src_red;
      cs_in[1] = req_if.payload.src_green;
      cs_in[2] = req_if.payload.src_blue;
      cd_in[0] = req_if.payload.dst_red;
      cd_in[1] = req_if.payload.dst_green;
      cd_in[2] = req_if.payload.dst_blue;
      w1_in = PROD_W'(req_if.payload.dst_alpha)
            * PROD_W'(ALPHA_OPAQUE - req_if.payload.src_alpha);
      for (int c = 0; c < LANES; c++) begin
         ps1_in[c] = PROD_W'(cs_in[c]) * PROD_W'(req_if.payload.src_alpha);
      end
      pass1_in = 1'b1;
      priority if (draw_mode_ff == DRAW_OVERWRITE
                   || req_if.payload.src_alpha == ALPHA_OPAQUE) begin
         pass_rsp1_in = '{out_alpha:   req_if.payload.src_alpha,
                          out_red:     req_if.payload.src_red,
                          out_green:   req_if.payload.src_green,
                          out_blue:    req_if.payload.src_blue,
                          write_pixel: 1'b1};
      end else if (req_if.payload.src_alpha == ALPHA_CLEAR) begin
         pass_rsp1_in = '{out_alpha:   req_if.payload.dst_alpha,
                          out_red:     req_if.payload.dst_red,
                          out_green:   req_if.payload.dst_green,
                          out_blue:    req_if.payload.dst_blue,
                          write_pixel: 1'b0};
      end else begin
         pass1_in     = 1'b0;
         pass_rsp1_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pass1_ff     <= pass1_in;
         pass_rsp1_ff <= pass_rsp1_in;
         as1_ff       <= req_if.payload.src_alpha;
         w1_ff        <= w1_in;
         for (int c = 0; c < LANES; c++) begin
            ps1_ff[c] <= ps1_in[c];
            cd1_ff[c] <= cd_in[c];
         end
      end
   end

   always_comb begin
      s2_in = ({as1_ff, PIX_W'(0)} - PROD_W'(as1_ff)) + w1_ff;
      for (int c = 0; c < LANES; c++) begin
         num2_in[c] = (NUM_W'({ps1_ff[c], PIX_W'(0)}) - NUM_W'(ps1_ff[c]))
                    + NUM_W'(cd1_ff[c]) * NUM_W'(w1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pass2_ff     <= pass1_ff;
         pass_rsp2_ff <= pass_rsp1_ff;
         s2_ff        <= s2_in;
         for (int c = 0; c < LANES; c++) begin
            num2_ff[c] <= num2_in[c];
         end
      end
   end

   for (genvar c = 0; c < LANES; c++) begin : g_lane
      apb_div_pipe u_div (
         .clock   (clock),
         .advance (advance),
         .num_in  (num2_ff[c]),
         .den_in  (s2_ff),
         .quo_out (quo[c])
      );
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (advance) begin
            sv_ff[k] <= (k == 0) ? v2_ff : sv_ff[(k == 0) ? 0 : k-1];
         end
      end
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (advance) begin
               spass_ff[k]  <= pass2_ff;
               srsp_ff[k]   <= pass_rsp2_ff;
               salpha_ff[k] <= alpha_div255(s2_ff);
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (advance) begin
               spass_ff[k]  <= spass_ff[k-1];
               srsp_ff[k]   <= srsp_ff[k-1];
               salpha_ff[k] <= salpha_ff[k-1];
            end
         end
      end
   end

   assign rsp_if.valid   = sv_ff[DIV_STAGES-1];
   assign rsp_if.payload = spass_ff[DIV_STAGES-1] ? srsp_ff[DIV_STAGES-1]
                         : rsp_payload_type'{out_alpha:   salpha_ff[DIV_STAGES-1],
                                             out_red:     quo[0],
                                             out_green:   quo[1],
                                             out_blue:    quo[2],
                                             write_pixel: 1'b1};

   a_blend_den_min: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !pass2_ff |-> s2_ff >= PROD_W'(ALPHA_OPAQUE))
      else $error("blend divisor below 255");

   a_blend_alpha_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !spass_ff[DIV_STAGES-1] |-> rsp_if.payload.out_alpha != ALPHA_CLEAR)
      else $error("blended item has zero alpha");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid after reset");

   a_stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !advance |=> v1_ff)
      else $error("stage 1 item lost during stall");

endmodule
